FILE: hw/rtl/gcdlcm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package gcdlcm_pkg;

	localparam int DEF_WIDTH = 32;
	localparam int OPERAND_W = 32;
	localparam int DIVISOR_W = 32;
	localparam int MULTIPLE_W = 64;

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_GCD   = 6'b000010,
		ST_SCALE = 6'b000100,
		ST_DIV   = 6'b001000,
		ST_MUL   = 6'b010000,
		ST_DONE  = 6'b100000
	} state_t;

endpackage

`default_nettype wire

FILE: hw/rtl/gcd_lcm_unit_core.sv
// gcd_lcm_unit_core: greatest common divisor and least common multiple of two
// unsigned operands, using only the low WIDTH bits of each operand.
// The input channel (in_valid, in_ready, operand_a, operand_b) takes one word
// when the block is idle. The output channel (out_valid, out_ready, divisor,
// multiple) returns one word for every input word, with the lcm at double width.
// A single add/subtract unit of WIDTH+1 bits does all the arithmetic under a
// small sequencer: a binary gcd loop of fewer than 2*WIDTH steps that ends once
// either value is zero, a scale step to restore the common power of two, WIDTH
// steps of restoring division of operand_a by the gcd, and WIDTH steps of
// shift-and-add multiplication of that quotient by operand_b. When either
// operand is zero the division and multiplication are skipped and the result
// is valid once the GCD and SCALE states have passed. in_ready is low from
// acceptance until the result word has been taken, so one word is in flight at
// a time. While the receiver holds out_ready low, the result word stays on the
// outputs unchanged.
// Reset returns the sequencer to idle and drops out_valid; no word survives it.
`timescale 1ns / 1ps
`default_nettype none

module gcd_lcm_unit_core #(
	parameter int WIDTH = gcdlcm_pkg::DEF_WIDTH
) (
	input  wire                                logic clk,
	input  wire                                logic arst_n,
	input  wire                                logic in_valid,
	output logic                               in_ready,
	input  wire logic [gcdlcm_pkg::OPERAND_W-1:0]  operand_a,
	input  wire logic [gcdlcm_pkg::OPERAND_W-1:0]  operand_b,
	output logic                               out_valid,
	input  wire                                logic out_ready,
	output logic [gcdlcm_pkg::DIVISOR_W-1:0]   divisor,
	output logic [gcdlcm_pkg::MULTIPLE_W-1:0]  multiple
);

	localparam int KW = $clog2(WIDTH);

	gcdlcm_pkg::state_t state_q;

	logic [WIDTH-1:0] a_q;
	logic [WIDTH-1:0] b_q;
	logic [WIDTH-1:0] u_q;
	logic [WIDTH-1:0] v_q;
	logic [WIDTH-1:0] g_q;
	logic [WIDTH-1:0] hi_q;
	logic [WIDTH-1:0] lo_q;
	logic [KW-1:0]    k_q;
	logic [KW-1:0]    cnt_q;

	logic [WIDTH:0]   alu_x;
	logic [WIDTH:0]   alu_y;
	logic             alu_sub;
	logic [WIDTH:0]   alu_res;
	logic             u_lt_v;
	logic             last_step;
	logic             any_zero;

	assign u_lt_v    = (u_q < v_q);
	assign last_step = (cnt_q == KW'(WIDTH - 1));
	assign any_zero  = (a_q == '0) || (b_q == '0);

	// Shared add/subtract unit.
	always_comb begin
		alu_x   = '0;
		alu_y   = '0;
		alu_sub = 1'b0;
		case (state_q)
			gcdlcm_pkg::ST_GCD: begin
				alu_x   = {1'b0, (u_lt_v ? v_q : u_q)};
				alu_y   = {1'b0, (u_lt_v ? u_q : v_q)};
				alu_sub = 1'b1;
			end
			gcdlcm_pkg::ST_DIV: begin
				alu_x   = {hi_q, lo_q[WIDTH-1]};
				alu_y   = {1'b0, g_q};
				alu_sub = 1'b1;
			end
			gcdlcm_pkg::ST_MUL: begin
				alu_x   = {1'b0, hi_q};
				alu_y   = lo_q[0] ? {1'b0, b_q} : '0;
				alu_sub = 1'b0;
			end
			default: begin
				alu_x   = '0;
				alu_y   = '0;
				alu_sub = 1'b0;
			end
		endcase
	end

	assign alu_res = alu_x + (alu_sub ? ~alu_y : alu_y) + (WIDTH + 1)'(alu_sub);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gcdlcm_pkg::ST_IDLE;
		end else begin
			case (state_q)
				gcdlcm_pkg::ST_IDLE: begin
					if (in_valid) begin
						state_q <= gcdlcm_pkg::ST_GCD;
					end
				end
				gcdlcm_pkg::ST_GCD: begin
					if (u_q == '0 || v_q == '0) begin
						state_q <= gcdlcm_pkg::ST_SCALE;
					end
				end
				gcdlcm_pkg::ST_SCALE: begin
					state_q <= any_zero ? gcdlcm_pkg::ST_DONE : gcdlcm_pkg::ST_DIV;
				end
				gcdlcm_pkg::ST_DIV: begin
					if (last_step) begin
						state_q <= gcdlcm_pkg::ST_MUL;
					end
				end
				gcdlcm_pkg::ST_MUL: begin
					if (last_step) begin
						state_q <= gcdlcm_pkg::ST_DONE;
					end
				end
				gcdlcm_pkg::ST_DONE: begin
					if (out_ready) begin
						state_q <= gcdlcm_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= gcdlcm_pkg::ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			gcdlcm_pkg::ST_IDLE: begin
				if (in_valid) begin
					a_q <= operand_a[WIDTH-1:0];
					b_q <= operand_b[WIDTH-1:0];
					u_q <= operand_a[WIDTH-1:0];
					v_q <= operand_b[WIDTH-1:0];
					k_q <= '0;
				end
			end
			gcdlcm_pkg::ST_GCD: begin
				if (u_q != '0 && v_q != '0) begin
					if (!u_q[0] && !v_q[0]) begin
						u_q <= u_q >> 1;
						v_q <= v_q >> 1;
						k_q <= k_q + KW'(1);
					end else if (!u_q[0]) begin
						u_q <= u_q >> 1;
					end else if (!v_q[0]) begin
						v_q <= v_q >> 1;
					end else if (u_lt_v) begin
						v_q <= alu_res[WIDTH-1:0] >> 1;
					end else begin
						u_q <= alu_res[WIDTH-1:0] >> 1;
					end
				end
			end
			gcdlcm_pkg::ST_SCALE: begin
				g_q   <= (u_q | v_q) << k_q;
				hi_q  <= '0;
				lo_q  <= any_zero ? '0 : a_q;
				cnt_q <= '0;
			end
			gcdlcm_pkg::ST_DIV: begin
				if (last_step) begin
					hi_q <= '0;
				end else if (!alu_res[WIDTH]) begin
					hi_q <= alu_res[WIDTH-1:0];
				end else begin
					hi_q <= {hi_q[WIDTH-2:0], lo_q[WIDTH-1]};
				end
				lo_q  <= {lo_q[WIDTH-2:0], !alu_res[WIDTH]};
				cnt_q <= last_step ? '0 : cnt_q + KW'(1);
			end
			gcdlcm_pkg::ST_MUL: begin
				hi_q  <= alu_res[WIDTH:1];
				lo_q  <= {alu_res[0], lo_q[WIDTH-1:1]};
				cnt_q <= cnt_q + KW'(1);
			end
			default: begin
			end
		endcase
	end

	assign in_ready  = (state_q == gcdlcm_pkg::ST_IDLE);
	assign out_valid = (state_q == gcdlcm_pkg::ST_DONE);
	assign divisor   = gcdlcm_pkg::DIVISOR_W'(g_q);
	assign multiple  = gcdlcm_pkg::MULTIPLE_W'({hi_q, lo_q});

	a_one_word_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input ready while a result word is pending");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (!in_ready && !out_valid))
		else $error("sequencer did not start after accepting a word");

	a_lcm_needs_gcd: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (multiple != '0)) |-> (divisor != '0))
		else $error("nonzero lcm with zero gcd");

endmodule

`default_nettype wire

FILE: tb/sv/gcd_lcm_unit_core_tb.sv
`timescale 1ns / 1ps

module gcd_lcm_unit_core_tb;

	localparam int TB_WIDTH = gcdlcm_pkg::DEF_WIDTH;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int SETTLE_CYCLES = 140;

	typedef struct packed {
		logic [gcdlcm_pkg::DIVISOR_W-1:0]  gcd;
		logic [gcdlcm_pkg::MULTIPLE_W-1:0] lcm;
	} gcd_lcm_t;

	logic                              clk = 1'b0;
	logic                              arst_n;
	logic                              in_valid;
	logic                              in_ready;
	logic [gcdlcm_pkg::OPERAND_W-1:0]  operand_a;
	logic [gcdlcm_pkg::OPERAND_W-1:0]  operand_b;
	logic                              out_valid;
	logic                              out_ready;
	logic [gcdlcm_pkg::DIVISOR_W-1:0]  divisor;
	logic [gcdlcm_pkg::MULTIPLE_W-1:0] multiple;

	gcd_lcm_t gcd_lcm_due[$];
	int       mismatch_count = 0;
	int       cycle_count = 0;
	int       stall_left = 0;
	bit       idling_en = 1'b0;

	gcd_lcm_unit_core #(.WIDTH(TB_WIDTH)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.operand_a(operand_a),
		.operand_b(operand_b),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.divisor(divisor),
		.multiple(multiple)
	);

	always #1 clk = ~clk;

	function automatic gcd_lcm_t calc_gcd_lcm(input logic [gcdlcm_pkg::OPERAND_W-1:0] a,
			input logic [gcdlcm_pkg::OPERAND_W-1:0] b);
		logic [63:0] mask;
		logic [63:0] x;
		logic [63:0] y;
		logic [63:0] hi;
		logic [63:0] lo;
		logic [63:0] rem;
		gcd_lcm_t r;
		mask = (64'd1 << TB_WIDTH) - 64'd1;
		x = {32'd0, a} & mask;
		y = {32'd0, b} & mask;
		hi = (x > y) ? x : y;
		lo = (x > y) ? y : x;
		while (lo != 64'd0) begin
			rem = hi % lo;
			hi = lo;
			lo = rem;
		end
		r.gcd = hi[gcdlcm_pkg::DIVISOR_W-1:0];
		r.lcm = (x != 64'd0 && y != 64'd0) ? (x / hi) * y : 64'd0;
		return r;
	endfunction

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			out_ready <= 1'b0;
		end else if (idling_en && $urandom_range(0, 4) == 0) begin
			stall_left = $urandom_range(1, 15) - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		gcd_lcm_t exp_r;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (gcd_lcm_due.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("Unexpected result word: divisor %0d multiple %0d",
							divisor, multiple);
				end else begin
					exp_r = gcd_lcm_due.pop_front();
					if (divisor !== exp_r.gcd) begin
						mismatch_count++;
						if (mismatch_count <= 10)
							$display("divisor mismatch: expected %0d, got %0d",
								exp_r.gcd, divisor);
					end
					if (multiple !== exp_r.lcm) begin
						mismatch_count++;
						if (mismatch_count <= 10)
							$display("multiple mismatch: expected %0d, got %0d",
								exp_r.lcm, multiple);
					end
				end
			end
			if (in_valid && in_ready)
				gcd_lcm_due.insert(gcd_lcm_due.size(), calc_gcd_lcm(operand_a, operand_b));
		end
	end

	task automatic send_word(input logic [gcdlcm_pkg::OPERAND_W-1:0] a,
			input logic [gcdlcm_pkg::OPERAND_W-1:0] b);
		if (idling_en && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		in_valid <= 1'b1;
		operand_a <= a;
		operand_b <= b;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (gcd_lcm_due.size() != 0) @(posedge clk);
	endtask

	task automatic test_directed();
		idling_en = 1'b0;
		send_word(32'd0, 32'd0);
		send_word(32'd0, 32'd12345);
		send_word(32'd987654, 32'd0);
		send_word(32'hFFFF_FFFF, 32'd0);
		send_word(32'd0, 32'hFFFF_FFFF);
		send_word(32'd1, 32'd1);
		send_word(32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_word(32'hFFFF_FFFF, 32'd1);
		send_word(32'd1, 32'hFFFF_FFFF);
		send_word(32'hFFFF_FFFF, 32'hFFFF_FFFE);
		send_word(32'd4294967291, 32'd4294967279);
		send_word(32'h8000_0000, 32'h4000_0000);
		send_word(32'h8000_0000, 32'h8000_0000);
		send_word(32'h8000_0000, 32'd1);
		send_word(32'd2971215073, 32'd1836311903);
		send_word(32'd1836311903, 32'd2971215073);
		send_word(32'd600, 32'd24);
		send_word(32'd24, 32'd600);
		send_word(32'hAAAA_AAAA, 32'h5555_5555);
		send_word(32'd65536, 32'd65535);
		send_word(32'd4294967291, 32'd4294967291);
		wait_drained();
	endtask

	task automatic test_random_mix(input int count);
		logic [gcdlcm_pkg::OPERAND_W-1:0] a;
		logic [gcdlcm_pkg::OPERAND_W-1:0] b;
		logic [gcdlcm_pkg::OPERAND_W-1:0] g;
		idling_en = 1'b1;
		for (int i = 0; i < count; i++) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3: begin
					a = $urandom;
					b = $urandom;
				end
				4, 5: begin
					g = $urandom_range(1, 65535);
					a = g * 32'($urandom_range(1, 65535));
					b = g * 32'($urandom_range(1, 65535));
				end
				6: begin
					a = $urandom_range(0, 255);
					b = $urandom_range(0, 255);
				end
				7: begin
					a = $urandom_range(0, 1) ? 32'd0 : $urandom;
					b = (a == 32'd0) ? $urandom : 32'd0;
				end
				8: begin
					a = $urandom >> $urandom_range(0, 31);
					b = 32'd1 << $urandom_range(0, 31);
				end
				default: begin
					a = $urandom;
					b = $urandom_range(0, 1) ? a : a >> $urandom_range(1, 8);
				end
			endcase
			send_word(a, b);
		end
	endtask

	task automatic test_drain_pauses(input int bursts);
		idling_en = 1'b1;
		for (int i = 0; i < bursts; i++) begin
			test_random_mix($urandom_range(1, 8));
			wait_drained();
			repeat ($urandom_range(0, 3)) @(posedge clk);
		end
	endtask

	task automatic test_steady_stream(input int count);
		test_random_mix(0);
		idling_en = 1'b0;
		for (int i = 0; i < count; i++)
			send_word($urandom, $urandom);
		wait_drained();
	endtask

	initial begin
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		operand_a <= '0;
		operand_b <= '0;
		out_ready <= 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random_mix(420);
		test_drain_pauses(15);
		test_steady_stream(100);

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && gcd_lcm_due.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
